### rtl/thact_pkg.sv
// Package for the thermostat hysteresis action unit: widths, register
// indexes, mode and action codes. No dependencies.
`default_nettype none

package thact_pkg;

    // Field and port widths
    localparam int TEMP_W = 16;
    localparam int BAND_W = 15;
    localparam int FLAG_W = 4;
    localparam int CFG_W  = 16;
    localparam int IDX_W  = 3;
    // Working width of the set point clamp: holds range_min - 2 * 32767
    localparam int WIDE_W = 18;

    localparam logic signed [WIDE_W-1:0] S16_MAX = 18'sd32767;
    localparam logic signed [WIDE_W-1:0] S16_MIN = -18'sd32768;

    // Feature flag bits
    localparam int FEAT_COOL     = 0;
    localparam int FEAT_HEAT     = 1;
    localparam int FEAT_FAN      = 2;
    localparam int FEAT_FAN_COOL = 3;

    // Configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_COOL_DEADBAND = 3'd0,
        REG_COOL_OVERRUN  = 3'd1,
        REG_HEAT_DEADBAND = 3'd2,
        REG_HEAT_OVERRUN  = 3'd3,
        REG_MIN_GAP       = 3'd4,
        REG_RANGE_MIN     = 3'd5,
        REG_RANGE_MAX     = 3'd6,
        REG_FEATURES      = 3'd7
    } t_reg_idx;

    // HVAC modes; code 7 behaves as auto
    typedef enum logic [2:0] {
        MODE_OFF       = 3'd0,
        MODE_HEAT_COOL = 3'd1,
        MODE_COOL      = 3'd2,
        MODE_HEAT      = 3'd3,
        MODE_FAN_ONLY  = 3'd4,
        MODE_DRY       = 3'd5,
        MODE_AUTO      = 3'd6
    } t_mode;

    // Actions
    typedef enum logic [2:0] {
        ACT_OFF  = 3'd0,
        ACT_IDLE = 3'd1,
        ACT_COOL = 3'd2,
        ACT_HEAT = 3'd3,
        ACT_FAN  = 3'd4,
        ACT_DRY  = 3'd5
    } t_action;

    // Reset values of the configuration registers
    localparam logic [BAND_W-1:0]        RST_BAND      = 15'd50;
    localparam logic signed [TEMP_W-1:0] RST_RANGE_MIN = 16'sd1000;
    localparam logic signed [TEMP_W-1:0] RST_RANGE_MAX = 16'sd3500;
    localparam logic [FLAG_W-1:0]        RST_FEATURES  = 4'hF;

endpackage

`default_nettype wire

### rtl/thact_req_if.sv
// Request channel of the thermostat action unit: one temperature sample,
// mode and set points. Uses thact_pkg for field widths.
`default_nettype none

interface thact_req_if;
    import thact_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [TEMP_W-1:0] temperature;
    logic                     temp_valid;
    logic [2:0]               hvac_mode;
    logic signed [TEMP_W-1:0] set_low;
    logic signed [TEMP_W-1:0] set_high;

    modport source (
        output valid, temperature, temp_valid, hvac_mode, set_low, set_high,
        input  ready
    );
    modport sink (
        input  valid, temperature, temp_valid, hvac_mode, set_low, set_high,
        output ready
    );
endinterface

`default_nettype wire

### rtl/thact_res_if.sv
// Result channel of the thermostat action unit: action, change flags and
// clamped set points. Uses thact_pkg for field widths.
`default_nettype none

interface thact_res_if;
    import thact_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [2:0]               action;
    logic                     action_changed;
    logic signed [TEMP_W-1:0] clamped_low;
    logic signed [TEMP_W-1:0] clamped_high;
    logic                     setpoint_changed;

    modport source (
        output valid, action, action_changed, clamped_low, clamped_high,
               setpoint_changed,
        input  ready
    );
    modport sink (
        input  valid, action, action_changed, clamped_low, clamped_high,
               setpoint_changed,
        output ready
    );
endinterface

`default_nettype wire

### rtl/thermostat_hysteresis_action_unit.sv
// Top level of the thermostat hysteresis action unit: set point clamp,
// banded action choice and change flags. Depends on thact_pkg and the
// thact_req_if / thact_res_if channel interfaces.
//
//  channel  | dir | handshake          | carries
//  ---------+-----+--------------------+-------------------------------------
//  i_req    | in  | valid/ready        | temperature, temp_valid, hvac_mode,
//           |     |                    | set_low, set_high
//  o_res    | out | valid/ready        | action, action_changed, clamped_low,
//           |     |                    | clamped_high, setpoint_changed
//  i_cfg_*  | in  | write enable only  | register index, data
//
// One request per cycle sustained while results are taken; a request passes
// through the input register, then the result register, which presents
// its result.
// The stored action and set points are updated as a request moves from the
// input register into the result register, so the next request sees them.
// A stalled result holds the result register; the input register still takes
// one more request behind it. Synchronous active-low reset clears the
// configuration to its defaults and the history to "no request seen".
`default_nettype none

module thermostat_hysteresis_action_unit
    import thact_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_W-1:0]  i_cfg_data,
    thact_req_if.sink              i_req,
    thact_res_if.source            o_res
);

    // Configuration registers
    logic [BAND_W-1:0]        r_cool_db, r_cool_or, r_heat_db, r_heat_or, r_min_gap;
    logic signed [TEMP_W-1:0] r_range_min, r_range_max;
    logic [FLAG_W-1:0]        r_features;

    // Input register
    logic                     r_in_vld;
    logic signed [TEMP_W-1:0] r_temp, r_set_low, r_set_high;
    logic                     r_temp_ok;
    t_mode                    r_mode;

    // History
    t_action                  r_last_act;
    logic signed [TEMP_W-1:0] r_last_low, r_last_high;
    logic                     r_started;

    // Result register
    logic                     r_out_vld;
    t_action                  r_act;
    logic                     r_act_chg, r_sp_chg;
    logic signed [TEMP_W-1:0] r_out_low, r_out_high;

    // Combinational results
    logic                     advance;
    logic signed [WIDE_W-1:0] gap, lo_a, lo_b, hi_a, hi_b, hi_c, lo_c;
    logic signed [TEMP_W-1:0] n_low, n_high;
    logic signed [WIDE_W-1:0] t_w, hi_w, lo_w;
    logic                     hi_band_up, hi_band_dn, lo_band_dn, lo_band_up;
    logic                     cool_req, heat_req, fan_req;
    t_action                  n_act;
    logic                     n_act_chg, n_sp_chg;

    // Handshake: input register drains when the result register is free or its result is taken
    assign advance     = r_in_vld && (!r_out_vld || o_res.ready);
    assign i_req.ready = !r_in_vld || advance;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cool_db   <= RST_BAND;
            r_cool_or   <= RST_BAND;
            r_heat_db   <= RST_BAND;
            r_heat_or   <= RST_BAND;
            r_min_gap   <= RST_BAND;
            r_range_min <= RST_RANGE_MIN;
            r_range_max <= RST_RANGE_MAX;
            r_features  <= RST_FEATURES;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_COOL_DEADBAND: r_cool_db   <= i_cfg_data[BAND_W-1:0];
                REG_COOL_OVERRUN:  r_cool_or   <= i_cfg_data[BAND_W-1:0];
                REG_HEAT_DEADBAND: r_heat_db   <= i_cfg_data[BAND_W-1:0];
                REG_HEAT_OVERRUN:  r_heat_or   <= i_cfg_data[BAND_W-1:0];
                REG_MIN_GAP:       r_min_gap   <= i_cfg_data[BAND_W-1:0];
                REG_RANGE_MIN:     r_range_min <= $signed(i_cfg_data[TEMP_W-1:0]);
                REG_RANGE_MAX:     r_range_max <= $signed(i_cfg_data[TEMP_W-1:0]);
                REG_FEATURES:      r_features  <= i_cfg_data[FLAG_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_req.ready) begin
            r_in_vld <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_temp     <= i_req.temperature;
            r_temp_ok  <= i_req.temp_valid;
            r_mode     <= t_mode'(i_req.hvac_mode);
            r_set_low  <= i_req.set_low;
            r_set_high <= i_req.set_high;
        end
    end

    // Set point clamp: low point first, then high, then saturate to 16 bits
    always_comb begin
        logic signed [WIDE_W-1:0] rmin_w, rmax_w;
        rmin_w = WIDE_W'(r_range_min);
        rmax_w = WIDE_W'(r_range_max);
        gap    = $signed({{(WIDE_W-BAND_W){1'b0}}, r_min_gap});

        lo_a = WIDE_W'(r_set_low);
        if (lo_a < rmin_w) lo_a = rmin_w;
        lo_b = lo_a;
        if (lo_b > rmax_w - gap) lo_b = rmax_w - gap;
        hi_a = WIDE_W'(r_set_high);
        if (lo_b > hi_a - gap) hi_a = lo_b + gap;

        hi_b = hi_a;
        if (hi_b > rmax_w) hi_b = rmax_w;
        hi_c = hi_b;
        if (hi_c < rmin_w + gap) hi_c = rmin_w + gap;
        lo_c = lo_b;
        if (hi_c < lo_c + gap) lo_c = hi_c - gap;

        if (lo_c > S16_MAX)      n_low = TEMP_W'(S16_MAX);
        else if (lo_c < S16_MIN) n_low = TEMP_W'(S16_MIN);
        else                     n_low = lo_c[TEMP_W-1:0];
        if (hi_c > S16_MAX)      n_high = TEMP_W'(S16_MAX);
        else if (hi_c < S16_MIN) n_high = TEMP_W'(S16_MIN);
        else                     n_high = hi_c[TEMP_W-1:0];
    end

    // Band edges against the saturated set points
    always_comb begin
        t_w  = WIDE_W'(r_temp);
        hi_w = WIDE_W'(n_high);
        lo_w = WIDE_W'(n_low);
        hi_band_up = t_w > hi_w + $signed({{(WIDE_W-BAND_W){1'b0}}, r_cool_db});
        hi_band_dn = t_w < hi_w - $signed({{(WIDE_W-BAND_W){1'b0}}, r_cool_or});
        lo_band_dn = t_w < lo_w - $signed({{(WIDE_W-BAND_W){1'b0}}, r_heat_db});
        lo_band_up = t_w > lo_w + $signed({{(WIDE_W-BAND_W){1'b0}}, r_heat_or});
    end

    // Demand with hysteresis: inside the band keep the stored action
    always_comb begin
        cool_req = 1'b0;
        if (r_features[FEAT_COOL]) begin
            if (hi_band_up)      cool_req = 1'b1;
            else if (hi_band_dn) cool_req = 1'b0;
            else cool_req = (r_last_act == ACT_COOL) &&
                            (r_mode == MODE_HEAT_COOL || r_mode == MODE_COOL);
        end

        heat_req = 1'b0;
        if (r_features[FEAT_HEAT]) begin
            if (lo_band_dn)      heat_req = 1'b1;
            else if (lo_band_up) heat_req = 1'b0;
            else heat_req = (r_last_act == ACT_HEAT) &&
                            (r_mode == MODE_HEAT_COOL || r_mode == MODE_HEAT);
        end

        fan_req = 1'b0;
        if (r_features[FEAT_FAN]) begin
            if (!r_features[FEAT_FAN_COOL]) fan_req = 1'b1;
            else if (hi_band_up)            fan_req = 1'b1;
            else if (hi_band_dn)            fan_req = 1'b0;
            else fan_req = (r_last_act == ACT_FAN) && (r_mode == MODE_FAN_ONLY);
        end
    end

    // Action choice per mode
    always_comb begin
        n_act = ACT_IDLE;
        if (!r_temp_ok) begin
            n_act = ACT_OFF;
        end else begin
            case (r_mode)
                MODE_OFF:       n_act = ACT_OFF;
                MODE_FAN_ONLY:  if (fan_req) n_act = ACT_FAN;
                MODE_DRY:       n_act = ACT_DRY;
                MODE_HEAT_COOL: begin
                    if (cool_req && !heat_req)      n_act = ACT_COOL;
                    else if (heat_req && !cool_req) n_act = ACT_HEAT;
                end
                MODE_COOL:      if (cool_req) n_act = ACT_COOL;
                MODE_HEAT:      if (heat_req) n_act = ACT_HEAT;
                default:        n_act = ACT_IDLE;
            endcase
        end
    end

    // Change flags; off <-> idle does not count as an action change
    always_comb begin
        if (!r_started)               n_act_chg = 1'b1;
        else if (n_act == r_last_act) n_act_chg = 1'b0;
        else n_act_chg = !((n_act == ACT_OFF && r_last_act == ACT_IDLE) ||
                           (n_act == ACT_IDLE && r_last_act == ACT_OFF));
        n_sp_chg = !r_started || (n_low != r_last_low) || (n_high != r_last_high);
    end

    // History and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_act  <= ACT_OFF;
            r_last_low  <= '0;
            r_last_high <= '0;
            r_started   <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            if (advance) begin
                r_last_act  <= n_act;
                r_last_low  <= n_low;
                r_last_high <= n_high;
                r_started   <= 1'b1;
                r_out_vld   <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld   <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_act      <= n_act;
            r_act_chg  <= n_act_chg;
            r_sp_chg   <= n_sp_chg;
            r_out_low  <= n_low;
            r_out_high <= n_high;
        end
    end

    assign o_res.valid            = r_out_vld;
    assign o_res.action           = r_act;
    assign o_res.action_changed   = r_act_chg;
    assign o_res.clamped_low      = r_out_low;
    assign o_res.clamped_high     = r_out_high;
    assign o_res.setpoint_changed = r_sp_chg;

endmodule

`default_nettype wire

### tb/thact_action_checker.sv
// Checker for the thermostat hysteresis action unit: watches the request,
// result and register-write ports, predicts each result and compares.
// Depends on thact_pkg and the thact_req_if / thact_res_if interfaces.
`timescale 1ns / 100ps

module thact_action_checker
    import thact_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    thact_req_if             req,
    thact_res_if             res,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_results
);

    typedef struct packed {
        t_action                  action;
        logic                     action_changed;
        logic signed [TEMP_W-1:0] clamped_low;
        logic signed [TEMP_W-1:0] clamped_high;
        logic                     setpoint_changed;
    } t_action_result;

    // Shadow copy of the configuration, widened to int for exact arithmetic
    int          cool_db, cool_ov, heat_db, heat_ov, gap_min, rng_min, rng_max;
    logic [3:0]  feat;

    // Shadow copy of the history
    t_action     last_act;
    int          last_lo, last_hi;
    bit          started;

    t_action_result expected_q[$];
    int             n_fail = 0;
    int             n_results = 0;

    function automatic int sat16(int v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // Cooling band against the high set point
    function automatic bit cooling_wanted(int t, int hi, logic [2:0] m);
        if (!feat[FEAT_COOL]) return 1'b0;
        if (t > hi + cool_db) return 1'b1;
        if (t < hi - cool_ov) return 1'b0;
        return last_act == ACT_COOL && (m == MODE_HEAT_COOL || m == MODE_COOL);
    endfunction

    // Heating band against the low set point
    function automatic bit heating_wanted(int t, int lo, logic [2:0] m);
        if (!feat[FEAT_HEAT]) return 1'b0;
        if (t < lo - heat_db) return 1'b1;
        if (t > lo + heat_ov) return 1'b0;
        return last_act == ACT_HEAT && (m == MODE_HEAT_COOL || m == MODE_HEAT);
    endfunction

    // Fan only: free running unless fan cooling is supported
    function automatic bit fan_wanted(int t, int hi, logic [2:0] m);
        if (!feat[FEAT_FAN]) return 1'b0;
        if (!feat[FEAT_FAN_COOL]) return 1'b1;
        if (t > hi + cool_db) return 1'b1;
        if (t < hi - cool_ov) return 1'b0;
        return last_act == ACT_FAN && m == MODE_FAN_ONLY;
    endfunction

    // Clamp the set points, choose the action, update the history
    function automatic t_action_result predict_action(
        input logic signed [TEMP_W-1:0] temp,
        input logic                     tv,
        input logic [2:0]               mode,
        input logic signed [TEMP_W-1:0] req_lo,
        input logic signed [TEMP_W-1:0] req_hi
    );
        int             t, lo, hi;
        bit             c, h;
        t_action        act;
        t_action_result r;
        t  = temp;
        lo = req_lo;
        hi = req_hi;
        // low point first, then high point
        if (lo < rng_min) lo = rng_min;
        if (lo > rng_max - gap_min) lo = rng_max - gap_min;
        if (lo > hi - gap_min) hi = lo + gap_min;
        if (hi > rng_max) hi = rng_max;
        if (hi < rng_min + gap_min) hi = rng_min + gap_min;
        if (hi < lo + gap_min) lo = hi - gap_min;
        lo = sat16(lo);
        hi = sat16(hi);

        if (!tv || mode == MODE_OFF) begin
            act = ACT_OFF;
        end else begin
            act = ACT_IDLE;
            case (mode)
                MODE_FAN_ONLY: begin
                    if (fan_wanted(t, hi, mode)) act = ACT_FAN;
                end
                MODE_DRY: begin
                    act = ACT_DRY;
                end
                MODE_HEAT_COOL: begin
                    c = cooling_wanted(t, hi, mode);
                    h = heating_wanted(t, lo, mode);
                    if (c && !h) act = ACT_COOL;
                    else if (h && !c) act = ACT_HEAT;
                end
                MODE_COOL: begin
                    if (cooling_wanted(t, hi, mode)) act = ACT_COOL;
                end
                MODE_HEAT: begin
                    if (heating_wanted(t, lo, mode)) act = ACT_HEAT;
                end
                default: ;
            endcase
        end

        r.action = act;
        if (!started)
            r.action_changed = 1'b1;
        else if (act == last_act)
            r.action_changed = 1'b0;
        else
            // off <-> idle is not a change worth flagging
            r.action_changed = !((act == ACT_OFF && last_act == ACT_IDLE) ||
                                 (act == ACT_IDLE && last_act == ACT_OFF));
        r.clamped_low      = lo[TEMP_W-1:0];
        r.clamped_high     = hi[TEMP_W-1:0];
        r.setpoint_changed = !started || lo != last_lo || hi != last_hi;

        last_act = act;
        last_lo  = lo;
        last_hi  = hi;
        started  = 1'b1;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        n_fail++;
        $display("[%0t] result %0d: %s is %0d, expected %0d",
                 $time, n_results, field, got, want);
    endtask

    // Sample on the rising edge: compare results, predict requests, track writes
    always @(posedge i_clk) begin
        t_action_result want;
        if (!i_rst_n) begin
            cool_db  = RST_BAND;
            cool_ov  = RST_BAND;
            heat_db  = RST_BAND;
            heat_ov  = RST_BAND;
            gap_min  = RST_BAND;
            rng_min  = RST_RANGE_MIN;
            rng_max  = RST_RANGE_MAX;
            feat     = RST_FEATURES;
            last_act = ACT_OFF;
            last_lo  = 0;
            last_hi  = 0;
            started  = 1'b0;
            expected_q.delete();
        end else begin
            if (res.valid && res.ready) begin
                n_results++;
                if (expected_q.size() == 0) begin
                    report_mismatch("result with no request outstanding", 0, 0);
                end else begin
                    want = expected_q.pop_front();
                    if (res.action !== want.action)
                        report_mismatch("action", res.action, want.action);
                    if (res.action_changed !== want.action_changed)
                        report_mismatch("action_changed", res.action_changed,
                                        want.action_changed);
                    if (res.clamped_low !== want.clamped_low)
                        report_mismatch("clamped_low", res.clamped_low,
                                        want.clamped_low);
                    if (res.clamped_high !== want.clamped_high)
                        report_mismatch("clamped_high", res.clamped_high,
                                        want.clamped_high);
                    if (res.setpoint_changed !== want.setpoint_changed)
                        report_mismatch("setpoint_changed", res.setpoint_changed,
                                        want.setpoint_changed);
                end
            end
            if (req.valid && req.ready)
                expected_q.push_back(predict_action(req.temperature, req.temp_valid,
                                                    req.hvac_mode, req.set_low,
                                                    req.set_high));
            // only the low bits as wide as the register are kept
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_idx))
                    REG_COOL_DEADBAND: cool_db = int'(i_cfg_data[BAND_W-1:0]);
                    REG_COOL_OVERRUN:  cool_ov = int'(i_cfg_data[BAND_W-1:0]);
                    REG_HEAT_DEADBAND: heat_db = int'(i_cfg_data[BAND_W-1:0]);
                    REG_HEAT_OVERRUN:  heat_ov = int'(i_cfg_data[BAND_W-1:0]);
                    REG_MIN_GAP:       gap_min = int'(i_cfg_data[BAND_W-1:0]);
                    REG_RANGE_MIN:     rng_min = int'($signed(i_cfg_data));
                    REG_RANGE_MAX:     rng_max = int'($signed(i_cfg_data));
                    REG_FEATURES:      feat    = i_cfg_data[FLAG_W-1:0];
                    default: ;
                endcase
            end
        end
        o_fail_count <= n_fail;
        o_pending    <= expected_q.size();
        o_results    <= n_results;
    end

endmodule

### tb/tb_top.sv
// Top of the thermostat action unit testbench: clock, reset, register writes,
// request stimulus and result back-pressure. Uses thact_pkg, the channel
// interfaces and thact_action_checker for prediction and comparison.
`timescale 1ns / 100ps

module tb_top;
    import thact_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 50;
    // unused mode code, behaves as auto
    localparam logic [2:0] MODE_SPARE = 3'd7;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_we = 1'b0;
    logic [IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;

    thact_req_if req_ch ();
    thact_res_if res_ch ();

    int fail_count, pending, results;
    int cycles = 0;
    int n_sent = 0, n_directed = 0, n_settings = 0;
    bit quiet = 1'b0;
    int stall_left = 0;

    // Current setting, used to aim the stimulus at the bands
    int ph_min = 1000, ph_max = 3500, ph_gap = 50, ph_band = 50;
    // Random walk state
    int         t_walk, run_lo, run_hi;
    logic [2:0] run_mode;

    thermostat_hysteresis_action_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch),
        .o_res      (res_ch)
    );

    thact_action_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .req          (req_ch),
        .res          (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_results    (results)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("Some tests failed");
            $finish;
        end
    end

    // Mostly short idle stretches, now and then a long one
    function automatic int pick_len();
        if ($urandom_range(0, 15) == 0) return $urandom_range(15, 50);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic signed [TEMP_W-1:0] clip16(int v);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[TEMP_W-1:0];
    endfunction

    // Result side back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            stall_left   <= 0;
        end else if (stall_left > 0) begin
            res_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else if (!quiet && $urandom_range(0, 4) == 0) begin
            res_ch.ready <= 1'b0;
            stall_left   <= pick_len() - 1;
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    // One request: optional idle gap, then hold until taken
    task automatic send_req(
        input logic signed [TEMP_W-1:0] temp,
        input logic                     tv,
        input logic [2:0]               mode,
        input logic signed [TEMP_W-1:0] lo,
        input logic signed [TEMP_W-1:0] hi
    );
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 9) >= 6) gap = pick_len();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.temperature <= temp;
        req_ch.temp_valid  <= tv;
        req_ch.hvac_mode   <= mode;
        req_ch.set_low     <= lo;
        req_ch.set_high    <= hi;
        do @(posedge i_clk); while (!req_ch.ready);
        n_sent++;
    endtask

    // Drop valid and wait until every result is back
    task automatic settle();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    // Write all registers and remember the setting for stimulus shaping
    task automatic apply_cfg(
        input logic [CFG_W-1:0] cdb, input logic [CFG_W-1:0] cov,
        input logic [CFG_W-1:0] hdb, input logic [CFG_W-1:0] hov,
        input logic [CFG_W-1:0] gp,  input logic [CFG_W-1:0] rmn,
        input logic [CFG_W-1:0] rmx, input logic [FLAG_W-1:0] ft
    );
        int b;
        write_reg(REG_COOL_DEADBAND, cdb);
        write_reg(REG_COOL_OVERRUN,  cov);
        write_reg(REG_HEAT_DEADBAND, hdb);
        write_reg(REG_HEAT_OVERRUN,  hov);
        write_reg(REG_MIN_GAP,       gp);
        write_reg(REG_RANGE_MIN,     rmn);
        write_reg(REG_RANGE_MAX,     rmx);
        write_reg(REG_FEATURES,      CFG_W'(ft));
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        ph_min = $signed(rmn);
        ph_max = $signed(rmx);
        ph_gap = gp[BAND_W-1:0];
        b = cdb[BAND_W-1:0];
        if (cov[BAND_W-1:0] > b) b = cov[BAND_W-1:0];
        if (hdb[BAND_W-1:0] > b) b = hdb[BAND_W-1:0];
        if (hov[BAND_W-1:0] > b) b = hov[BAND_W-1:0];
        ph_band = b;
        n_settings++;
    endtask

    function automatic logic [CFG_W-1:0] pick_band();
        if ($urandom_range(0, 7) == 0) return CFG_W'($urandom);
        return CFG_W'($urandom_range(0, 300));
    endfunction

    // Setting for random phase ph; the first two are the extremes
    task automatic pick_setting(input int ph);
        int a, b, tmp;
        if (ph == 0) begin
            apply_cfg(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'h8000, 16'h7FFF, 4'hF);
        end else if (ph == 1) begin
            // widest bands, inverted range
            apply_cfg(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                      CFG_W'($urandom_range(0, 200)), 16'd3000, 16'd1500, 4'hF);
        end else begin
            a = int'($urandom_range(0, 4000)) - 1500;
            b = a + int'($urandom_range(200, 4000));
            if ($urandom_range(0, 9) == 0) begin
                tmp = a;
                a   = b;
                b   = tmp;
            end
            apply_cfg(pick_band(), pick_band(), pick_band(), pick_band(),
                      ($urandom_range(0, 7) == 0) ? CFG_W'($urandom)
                                                  : CFG_W'($urandom_range(0, 600)),
                      CFG_W'(clip16(a)), CFG_W'(clip16(b)),
                      $urandom_range(0, 1) ? 4'hF : FLAG_W'($urandom));
        end
    endtask

    function automatic logic [2:0] pick_mode();
        int r;
        r = $urandom_range(0, 11);
        if (r < 3) return MODE_HEAT_COOL;
        if (r < 5) return MODE_COOL;
        if (r < 7) return MODE_HEAT;
        if (r < 9) return MODE_FAN_ONLY;
        if (r == 9) return MODE_DRY;
        if (r == 10) return MODE_OFF;
        return $urandom_range(0, 1) ? MODE_AUTO : MODE_SPARE;
    endfunction

    task automatic new_setpoints();
        int a, b;
        a = (ph_min < ph_max) ? ph_min : ph_max;
        b = (ph_min < ph_max) ? ph_max : ph_min;
        run_lo = a - 100 + int'($urandom_range(0, b - a + 200));
        run_hi = run_lo + ph_gap + int'($urandom_range(0, 800)) - 100;
    endtask

    // Mostly a temperature walking around the set points, some pure noise
    task automatic random_item();
        int spread, step;
        if ($urandom_range(0, 9) == 0) begin
            send_req(TEMP_W'($urandom), 1'($urandom), 3'($urandom),
                     TEMP_W'($urandom), TEMP_W'($urandom));
        end else begin
            if ($urandom_range(0, 9) == 0) run_mode = pick_mode();
            if ($urandom_range(0, 7) == 0) new_setpoints();
            spread = ph_band + 60;
            if (spread > 3000) spread = 3000;
            step = spread / 4 + 1;
            if ($urandom_range(0, 7) == 0)
                t_walk = ($urandom_range(0, 1) ? run_hi : run_lo)
                         + int'($urandom_range(0, 2 * spread)) - spread;
            else
                t_walk = t_walk + int'($urandom_range(0, 2 * step)) - step;
            send_req(clip16(t_walk), $urandom_range(0, 19) != 0, run_mode,
                     clip16(run_lo), clip16(run_hi));
        end
    endtask

    initial begin
        req_ch.valid       = 1'b0;
        req_ch.temperature = '0;
        req_ch.temp_valid  = 1'b0;
        req_ch.hvac_mode   = MODE_OFF;
        req_ch.set_low     = '0;
        req_ch.set_high    = '0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed, reset setting: set points 20.00 / 25.00, bands 0.50
        send_req(16'sd2200, 1'b1, MODE_HEAT_COOL, 16'sd2000, 16'sd2500); // first request
        send_req(16'sd2200, 1'b1, MODE_HEAT_COOL, 16'sd2000, 16'sd2500); // nothing changes
        send_req(16'sd2200, 1'b0, MODE_HEAT_COOL, 16'sd2000, 16'sd2500); // invalid sample
        send_req(16'sd3000, 1'b1, MODE_OFF,       16'sd2000, 16'sd2500);
        send_req(16'sd2600, 1'b1, MODE_COOL,      16'sd2000, 16'sd2500); // start cooling
        send_req(16'sd2460, 1'b1, MODE_COOL,      16'sd2000, 16'sd2500); // inside band
        send_req(16'sd2440, 1'b1, MODE_COOL,      16'sd2000, 16'sd2500); // overrun
        send_req(16'sd1940, 1'b1, MODE_HEAT,      16'sd2000, 16'sd2500); // start heating
        send_req(16'sd2040, 1'b1, MODE_HEAT,      16'sd2000, 16'sd2500);
        send_req(16'sd2060, 1'b1, MODE_HEAT,      16'sd2000, 16'sd2500);
        send_req(16'sd2600, 1'b1, MODE_HEAT_COOL, 16'sd2000, 16'sd2500);
        send_req(16'sd1900, 1'b1, MODE_HEAT_COOL, 16'sd2000, 16'sd2500);
        send_req(16'sd2600, 1'b1, MODE_FAN_ONLY,  16'sd2000, 16'sd2500); // fan cooling
        send_req(16'sd2480, 1'b1, MODE_FAN_ONLY,  16'sd2000, 16'sd2500);
        send_req(16'sd2400, 1'b1, MODE_FAN_ONLY,  16'sd2000, 16'sd2500);
        send_req(-16'sd32768, 1'b1, MODE_DRY,     16'sd2000, 16'sd2500);
        send_req(16'sd32767, 1'b1, MODE_AUTO,     16'sd2000, 16'sd2500);
        send_req(16'sd2200, 1'b1, MODE_SPARE,     16'sd2000, 16'sd2500);
        // set points at the field extremes, both orders
        send_req(16'sd32767, 1'b1, MODE_HEAT_COOL, 16'sd32767, -16'sd32768);
        send_req(-16'sd32768, 1'b1, MODE_COOL, -16'sd32768, 16'sd32767);
        settle();

        // Widest gap, range turned round: the clamp leaves the 16-bit range
        apply_cfg(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h8000, 4'hF);
        send_req(16'sd0, 1'b1, MODE_HEAT_COOL, 16'sd0, 16'sd0);
        send_req(16'sd32767, 1'b1, MODE_COOL, -16'sd32768, 16'sd32767);
        settle();
        // No features: every requirement falls back to idle
        apply_cfg(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'h8000, 16'h7FFF, 4'h0);
        send_req(16'sd32767, 1'b1, MODE_HEAT_COOL, 16'sd0, 16'sd100);
        send_req(-16'sd32768, 1'b1, MODE_HEAT, 16'sd0, 16'sd100);
        settle();
        // Fan only without fan cooling: fan always runs
        apply_cfg(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'h8000, 16'h7FFF,
                  4'b1 << FEAT_FAN);
        send_req(-16'sd32768, 1'b1, MODE_FAN_ONLY, 16'sd0, 16'sd100);
        n_directed = n_sent;

        // Random phases, each under its own setting
        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            pick_setting(ph);
            quiet    = ($urandom_range(0, 3) == 0);
            run_mode = pick_mode();
            new_setpoints();
            t_walk = run_hi;
            for (int i = 0; i < PHASE_ITEMS; i++)
                random_item();
        end

        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (8) @(posedge i_clk);

        $display("Sent %0d requests (%0d directed) under %0d register settings,",
                 n_sent, n_directed, n_settings + 1);
        $display("including inverted and saturating ranges; %0d results checked, %0d mismatches",
                 results, fail_count);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
